// ===== rtl/f2p_pkg.sv =====
// Package for the float32 to PCM encoder: payload structs, format codes and
// full-scale constants. No dependencies.
package f2p_pkg;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] packed_bytes;
    logic [2:0]  byte_count;
    logic        last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    FMT_I16_LE = 3'd0,
    FMT_I16_BE = 3'd1,
    FMT_I24_LE = 3'd2,
    FMT_I24_BE = 3'd3,
    FMT_I32_LE = 3'd4,
    FMT_I32_BE = 3'd5,
    FMT_F32_LE = 3'd6,
    FMT_F32_BE = 3'd7
  } fmt_t;

  localparam logic [30:0] FULL16 = 31'h0000_7fff;
  localparam logic [30:0] FULL24 = 31'h007f_ffff;
  localparam logic [30:0] FULL32 = 31'h7fff_ffff;

  // Decode stage to multiply stage.
  typedef struct packed {
    logic [31:0] bits;
    logic        last;
    fmt_t        fmt;
    logic [23:0] mant;
    logic [30:0] full;
    logic [5:0]  shift;
    logic        zero;
    logic        sat;
  } dec_t;

  // Multiply stage to round stage.
  typedef struct packed {
    logic [31:0] bits;
    logic        last;
    fmt_t        fmt;
    logic [54:0] prod;
    logic [30:0] full;
    logic [5:0]  shift;
    logic        zero;
    logic        sat;
  } mul_t;

endpackage

// ===== rtl/float_to_pcm_encoder_top.sv =====
// Top level of the float32 to PCM encoder: decode stage, multiply and round
// stages. Uses f2p_pkg, f2p_pipe_ctl, f2p_mul and f2p_round.
//
//   channel  ports                      role
//   in       in_valid/in_ready/in_data  float sample transaction
//   out      out_valid/out_ready/out_data packed PCM transaction
//   cfg      cfg_we/cfg_wdata           output format register
//
// One transaction per cycle unless the output stalls; registers: decode,
// multiply, round and pack. The 24 by 31 bit multiplier sets the depth.
// Reset is synchronous and clears the valid bits and the format to int16 LE.
// A stall at the output holds every full stage; nothing is lost or repeated.
module float_to_pcm_encoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  f2p_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output f2p_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata
);
  f2p_pkg::fmt_t fmt_r;
  f2p_pkg::dec_t dec_r;
  f2p_pkg::dec_t dec_nxt;
  f2p_pkg::mul_t mul_data;
  logic          dec_valid;
  logic          dec_ready;
  logic          mul_valid;
  logic          mul_ready;
  logic          load;
  logic [7:0]    expo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= f2p_pkg::FMT_I16_LE;
    end else if (cfg_we) begin
      fmt_r <= f2p_pkg::fmt_t'(cfg_wdata);
    end
  end

  f2p_pipe_ctl u_dec_ctl (
    .clk(clk), .rst_n(rst_n), .up_valid(in_valid), .up_ready(in_ready),
    .dn_valid(dec_valid), .dn_ready(dec_ready), .load(load)
  );

  always_comb begin
    expo         = in_data.sample_bits[30:23];
    dec_nxt.bits = in_data.sample_bits;
    dec_nxt.last = in_data.last_sample;
    dec_nxt.fmt  = fmt_r;
    dec_nxt.mant = {1'b1, in_data.sample_bits[22:0]};
    if (fmt_r == f2p_pkg::FMT_I16_LE || fmt_r == f2p_pkg::FMT_I16_BE) begin
      dec_nxt.full = f2p_pkg::FULL16;
    end else if (fmt_r == f2p_pkg::FMT_I24_LE || fmt_r == f2p_pkg::FMT_I24_BE) begin
      dec_nxt.full = f2p_pkg::FULL24;
    end else begin
      dec_nxt.full = f2p_pkg::FULL32;
    end
    dec_nxt.sat  = expo >= 8'd127 && expo != 8'hff;
    dec_nxt.zero = expo == 8'd0 || expo < 8'd95 ||
                   (expo == 8'hff && in_data.sample_bits[22:0] != 23'd0);
    if (expo == 8'hff && in_data.sample_bits[22:0] == 23'd0) begin
      dec_nxt.sat = 1'b1;
    end
    dec_nxt.shift = 6'(8'd150 - expo);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_r <= dec_nxt;
    end
  end

  f2p_mul u_mul (
    .clk(clk), .rst_n(rst_n), .up_valid(dec_valid), .up_ready(dec_ready),
    .up_data(dec_r), .dn_valid(mul_valid), .dn_ready(mul_ready),
    .dn_data(mul_data)
  );

  f2p_round u_round (
    .clk(clk), .rst_n(rst_n), .up_valid(mul_valid), .up_ready(mul_ready),
    .up_data(mul_data), .dn_valid(out_valid), .dn_ready(out_ready),
    .dn_data(out_data)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !dec_valid |-> in_ready) else $error("input stalled with empty stage");
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_count == 3'd2 || out_data.byte_count == 3'd3 ||
                   out_data.byte_count == 3'd4)) else $error("bad byte count");
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_count == 3'd2 |-> out_data.packed_bytes[31:16] == 16'd0)
    else $error("unused lanes not zero");
endmodule

// ===== rtl/f2p_pipe_ctl.sv =====
// Pipeline control for one stage: valid register and enable, with the stall
// travelling back. Depends on nothing.
module f2p_pipe_ctl (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  output logic dn_valid,
  input  logic dn_ready,
  output logic load
);
  logic valid_r;
  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;
  assign dn_valid = valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end
endmodule

// ===== rtl/f2p_mul.sv =====
// Multiply stage: mantissa times full scale, registered. Uses f2p_pkg and
// f2p_pipe_ctl.
module f2p_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  f2p_pkg::dec_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output f2p_pkg::mul_t dn_data
);
  logic          load;
  f2p_pkg::mul_t data_r;
  f2p_pipe_ctl u_ctl (
    .clk(clk), .rst_n(rst_n), .up_valid(up_valid), .up_ready(up_ready),
    .dn_valid(dn_valid), .dn_ready(dn_ready), .load(load)
  );
  always_ff @(posedge clk) begin
    if (load) begin
      data_r.bits  <= up_data.bits;
      data_r.last  <= up_data.last;
      data_r.fmt   <= up_data.fmt;
      data_r.prod  <= up_data.mant * up_data.full;
      data_r.full  <= up_data.full;
      data_r.shift <= up_data.shift;
      data_r.zero  <= up_data.zero;
      data_r.sat   <= up_data.sat;
    end
  end
  assign dn_data = data_r;
endmodule

// ===== rtl/f2p_round.sv =====
// Round and pack stage: shift, round half to even, negate, byte order.
// Uses f2p_pkg and f2p_pipe_ctl.
module f2p_round (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  f2p_pkg::mul_t     up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output f2p_pkg::out_item_t dn_data
);
  logic               load;
  f2p_pkg::out_item_t data_r;
  f2p_pkg::out_item_t data_nxt;
  logic [54:0] q;
  logic [54:0] rem;
  logic [54:0] half;
  logic [54:0] mask;
  logic [31:0] mag;
  logic [31:0] val;
  logic [31:0] v;

  f2p_pipe_ctl u_ctl (
    .clk(clk), .rst_n(rst_n), .up_valid(up_valid), .up_ready(up_ready),
    .dn_valid(dn_valid), .dn_ready(dn_ready), .load(load)
  );

  always_comb begin
    q    = up_data.prod >> up_data.shift;
    mask = (55'd1 << up_data.shift) - 55'd1;
    rem  = up_data.prod & mask;
    half = 55'd1 << (up_data.shift - 6'd1);
    mag  = q[31:0];
    if (rem > half || (rem == half && q[0])) begin
      mag = q[31:0] + 32'd1;
    end
    if (up_data.sat) begin
      mag = {1'b0, up_data.full};
    end
    if (up_data.zero) begin
      mag = 32'd0;
    end
    val = up_data.bits[31] ? (32'd0 - mag) : mag;
    data_nxt.last_out = up_data.last;
    unique case (up_data.fmt)
      f2p_pkg::FMT_I16_LE: begin
        v = {16'd0, val[15:0]};
        data_nxt.byte_count = 3'd2;
      end
      f2p_pkg::FMT_I16_BE: begin
        v = {16'd0, val[7:0], val[15:8]};
        data_nxt.byte_count = 3'd2;
      end
      f2p_pkg::FMT_I24_LE: begin
        v = {8'd0, val[23:0]};
        data_nxt.byte_count = 3'd3;
      end
      f2p_pkg::FMT_I24_BE: begin
        v = {8'd0, val[7:0], val[15:8], val[23:16]};
        data_nxt.byte_count = 3'd3;
      end
      f2p_pkg::FMT_I32_LE: begin
        v = val;
        data_nxt.byte_count = 3'd4;
      end
      f2p_pkg::FMT_I32_BE: begin
        v = {val[7:0], val[15:8], val[23:16], val[31:24]};
        data_nxt.byte_count = 3'd4;
      end
      f2p_pkg::FMT_F32_LE: begin
        v = up_data.bits;
        data_nxt.byte_count = 3'd4;
      end
      default: begin
        v = {up_data.bits[7:0], up_data.bits[15:8], up_data.bits[23:16],
             up_data.bits[31:24]};
        data_nxt.byte_count = 3'd4;
      end
    endcase
    data_nxt.packed_bytes = v;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end
  assign dn_data = data_r;
endmodule

// ===== test/float_to_pcm_encoder_checker.sv =====
// Checker for the float32 to PCM encoder: watches the input and output channels,
// predicts each packed result and compares it. Depends on f2p_pkg.
module float_to_pcm_encoder_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  f2p_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  f2p_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  output int                 errors,
  output int                 pending
);
  f2p_pkg::fmt_t      cur_fmt;
  f2p_pkg::out_item_t expected_pcm[$];

  function automatic logic [31:0] scale_sample(logic [31:0] bits, logic [31:0] full);
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] mag;
    int          sh;
    expo = bits[30:23];
    frac = bits[22:0];
    if (expo == 8'hff && frac != 0) return 32'd0;
    if (expo >= 8'd127) begin
      mag = full;
    end else if (expo == 0) begin
      mag = 0;
    end else begin
      prod = {40'd0, 1'b1, frac} * {32'd0, full};
      sh = 150 - expo;
      if (sh > 56) begin
        mag = 0;
      end else begin
        q = prod >> sh;
        rem = prod & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        mag = q;
      end
    end
    return bits[31] ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  function automatic f2p_pkg::out_item_t encode_sample(f2p_pkg::fmt_t f,
                                                       f2p_pkg::in_item_t it);
    f2p_pkg::out_item_t r;
    logic [31:0]        v;
    int                 n;
    case (f)
      f2p_pkg::FMT_I16_LE, f2p_pkg::FMT_I16_BE: begin
        n = 2;
        v = scale_sample(it.sample_bits, 32'(f2p_pkg::FULL16)) & 32'hffff;
      end
      f2p_pkg::FMT_I24_LE, f2p_pkg::FMT_I24_BE: begin
        n = 3;
        v = scale_sample(it.sample_bits, 32'(f2p_pkg::FULL24)) & 32'hff_ffff;
      end
      f2p_pkg::FMT_I32_LE, f2p_pkg::FMT_I32_BE: begin
        n = 4;
        v = scale_sample(it.sample_bits, 32'(f2p_pkg::FULL32));
      end
      default: begin
        n = 4;
        v = it.sample_bits;
      end
    endcase
    r.packed_bytes = 0;
    if (f[0]) begin
      for (int i = 0; i < n; i++) r.packed_bytes[8*(n-1-i) +: 8] = v[8*i +: 8];
    end else begin
      r.packed_bytes = v;
    end
    r.byte_count = 3'(n);
    r.last_out = it.last_sample;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    f2p_pkg::out_item_t w;
    if (!rst_n) begin
      cur_fmt <= f2p_pkg::FMT_I16_LE;
      expected_pcm.delete();
      errors = 0;
    end else begin
      if (in_valid && in_ready) expected_pcm.push_back(encode_sample(cur_fmt, in_data));
      if (out_valid && out_ready) begin
        if (expected_pcm.size() == 0) begin
          report_mismatch("unexpected transaction", out_data.packed_bytes, 0);
        end else begin
          w = expected_pcm.pop_front();
          if (out_data.packed_bytes !== w.packed_bytes)
            report_mismatch("packed_bytes", out_data.packed_bytes, w.packed_bytes);
          if (out_data.byte_count !== w.byte_count)
            report_mismatch("byte_count", out_data.byte_count, w.byte_count);
          if (out_data.last_out !== w.last_out)
            report_mismatch("last_out", out_data.last_out, w.last_out);
        end
      end
      if (cfg_we) cur_fmt <= f2p_pkg::fmt_t'(cfg_wdata);
    end
    pending = expected_pcm.size();
  end
endmodule

// ===== test/float_to_pcm_encoder_top_test.sv =====
// Testbench top for the float32 to PCM encoder: drives samples and format writes
// with random idling, gives the verdict. Uses f2p_pkg, the top and the checker.
module float_to_pcm_encoder_top_test;
  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  f2p_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 0;
  f2p_pkg::out_item_t out_data;
  logic               cfg_we = 0;
  logic [2:0]         cfg_wdata = 0;
  int                 errors;
  int                 pending;
  int                 cycles = 0;
  logic               calm = 0;
  localparam int LIMIT = 400000;

  always #5 clk = ~clk;

  float_to_pcm_encoder_top DUT (.*);

  float_to_pcm_encoder_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : sink
    int k;
    @(posedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        k = $urandom_range(1, 11);
        repeat (k) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 127)), 23'($urandom())};
      2: return {$urandom_range(0, 1) == 1, 8'($urandom_range(60, 100)), 23'($urandom())};
      3: return {$urandom_range(0, 1) == 1, 8'($urandom_range(126, 128)),
                 23'($urandom_range(0, 3))};
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 126)),
                       23'($urandom())};
    endcase
  endfunction

  task automatic send_sample(logic [31:0] bits, logic last);
    int k;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      k = $urandom_range(1, 11);
      repeat (k) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{sample_bits: bits, last_sample: last};
    @(posedge clk iff in_ready);
  endtask

  task automatic set_format(f2p_pkg::fmt_t f);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  logic [31:0] edge_samples[22] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000, 32'h7f80_0000,
    32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff, 32'h0000_0001, 32'h807f_ffff,
    32'h3f00_0000, 32'hbf00_0000, 32'h3f7f_ffff, 32'hbf7f_ffff, 32'h3800_0000,
    32'h3700_0000, 32'h3780_0000, 32'h2f00_0000, 32'h4000_0000, 32'h7f7f_ffff,
    32'h0080_0000, 32'h3eaa_aaab
  };

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int f = 0; f < 8; f++) begin
      if (f != 0) set_format(f2p_pkg::fmt_t'(f));
      foreach (edge_samples[i]) send_sample(edge_samples[i], i == 21);
    end
    for (int p = 0; p < 16; p++) begin
      set_format(p < 2 ? (p == 0 ? f2p_pkg::FMT_F32_BE : f2p_pkg::FMT_I16_LE)
                       : f2p_pkg::fmt_t'($urandom_range(0, 7)));
      if (p >= 13) calm = 1;
      for (int i = 0; i < 125; i++) send_sample(random_sample(), $urandom_range(0, 15) == 0);
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
